// File: rtl/jts_pkg.sv
package jts_pkg;

  // fixed field widths of the channels
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ID_W       = 29;
  localparam int unsigned STAMP_W    = 48;
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned PRIO_W     = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_CNT_W  = 32;
  localparam int unsigned OUT_TIME_W = 48;

  // table geometry
  localparam int unsigned PGN_ENTRIES = 65536;
  localparam int unsigned PGN_AW      = $clog2(PGN_ENTRIES);
  localparam int unsigned PAIR_AW     = 16;
  localparam int unsigned SMALL_AW    = 8;

  // defaults for the top level parameters
  localparam int unsigned DEF_COUNT_WIDTH = 32;
  localparam int unsigned DEF_TIME_WIDTH  = 48;

  localparam logic [BYTE_W-1:0] BCAST_FORMAT = 8'd240;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // table select codes
  localparam logic [SEL_W-1:0] SEL_PGN    = 3'd0;
  localparam logic [SEL_W-1:0] SEL_FORMAT = 3'd1;
  localparam logic [SEL_W-1:0] SEL_BSRC   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_SRC    = 3'd3;
  localparam logic [SEL_W-1:0] SEL_PAIR   = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic in_ready;
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic in_valid;
  } ctrl_sts_t;

endpackage

// File: rtl/jts_in_if.sv
interface jts_in_if;
  import jts_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ID_W-1:0]    can_id;
  logic [STAMP_W-1:0] stamp_us;
  logic [SEL_W-1:0]   table_sel;
  logic [INDEX_W-1:0] query_index;

  modport source (
    output valid, cmd, can_id, stamp_us, table_sel, query_index,
    input  ready
  );
  modport sink (
    input  valid, cmd, can_id, stamp_us, table_sel, query_index,
    output ready
  );
endinterface

// File: rtl/jts_out_if.sv
interface jts_out_if;
  import jts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PRIO_W-1:0]     priority_res;
  logic [BYTE_W-1:0]     pdu_format;
  logic [BYTE_W-1:0]     pdu_specific;
  logic [BYTE_W-1:0]     source_addr;
  logic                  is_broadcast;
  logic [OUT_CNT_W-1:0]  count_value;
  logic [OUT_TIME_W-1:0] first_time;
  logic [OUT_TIME_W-1:0] last_time;
  logic [OUT_CNT_W-1:0]  total_lines;
  logic [OUT_CNT_W-1:0]  read_frames;
  logic [OUT_CNT_W-1:0]  broadcast_total;
  logic [OUT_CNT_W-1:0]  addressed_total;

  modport source (
    output valid, priority_res, pdu_format, pdu_specific, source_addr, is_broadcast,
           count_value, first_time, last_time, total_lines, read_frames,
           broadcast_total, addressed_total,
    input  ready
  );
  modport sink (
    input  valid, priority_res, pdu_format, pdu_specific, source_addr, is_broadcast,
           count_value, first_time, last_time, total_lines, read_frames,
           broadcast_total, addressed_total,
    output ready
  );
endinterface

// File: rtl/jts_ctrl.sv
module jts_ctrl import jts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (sts_i.in_valid && sts_i.out_free) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.in_ready = sts_i.out_free;
        cmd_o.capture  = sts_i.out_free && sts_i.in_valid;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/jts_datapath.sv
module jts_datapath import jts_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  jts_in_if.sink    in_i,
  jts_out_if.source out_o
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned TW = TIME_WIDTH;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // clearing sweep counter
  logic [PGN_AW-1:0] clr_q;
  logic              small_clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign small_clr = cmd_i.clr_en && (clr_q[PGN_AW-1:SMALL_AW] == '0);

  // read addresses from the incoming payload
  logic                  in_query;
  logic [PGN_AW-1:0]     pgn_ra;
  logic [PAIR_AW-1:0]    pair_ra;
  logic [SMALL_AW-1:0]   fmt_ra, src_ra;

  assign in_query = (in_i.cmd == CMD_QUERY);
  assign pgn_ra   = in_query ? PGN_AW'(in_i.query_index) : PGN_AW'(in_i.can_id[23:8]);
  assign pair_ra  = in_query ? in_i.query_index : {in_i.can_id[7:0], in_i.can_id[15:8]};
  assign fmt_ra   = in_query ? in_i.query_index[7:0] : in_i.can_id[23:16];
  assign src_ra   = in_query ? in_i.query_index[7:0] : in_i.can_id[7:0];

  // captured item
  logic [CMD_W-1:0]    cmd_q;
  logic [ID_W-1:0]     id_q;
  logic [TW-1:0]       t_q;
  logic [SEL_W-1:0]    sel_q;
  logic [INDEX_W-1:0]  qi_q;
  logic [PGN_AW-1:0]   pgn_a_q;
  logic [PAIR_AW-1:0]  pair_a_q;
  logic [SMALL_AW-1:0] fmt_a_q, src_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= in_i.cmd;
      id_q     <= in_i.can_id;
      t_q      <= TW'(in_i.stamp_us);
      sel_q    <= in_i.table_sel;
      qi_q     <= in_i.query_index;
      pgn_a_q  <= pgn_ra;
      pair_a_q <= pair_ra;
      fmt_a_q  <= fmt_ra;
      src_a_q  <= src_ra;
    end
  end

  // memories
  logic [CW-1:0]     pgn_cnt_mem   [PGN_ENTRIES];
  logic [PRIO_W-1:0] pgn_pri_mem   [PGN_ENTRIES];
  logic [BYTE_W-1:0] pgn_src_mem   [PGN_ENTRIES];
  logic [TW-1:0]     pgn_first_mem [PGN_ENTRIES];
  logic [TW-1:0]     pgn_last_mem  [PGN_ENTRIES];
  logic [CW-1:0]     pair_mem      [2**PAIR_AW];
  logic [CW-1:0]     fmt_mem       [2**SMALL_AW];
  logic [CW-1:0]     bsrc_mem      [2**SMALL_AW];
  logic [CW-1:0]     src_mem       [2**SMALL_AW];

  logic [CW-1:0]     pgn_cnt_rd, pair_rd, fmt_rd, bsrc_rd, src_rd;
  logic [PRIO_W-1:0] pgn_pri_rd;
  logic [BYTE_W-1:0] pgn_src_rd;
  logic [TW-1:0]     pgn_first_rd, pgn_last_rd;

  // update values
  logic              frame_we, addr_we, bc_we;
  logic              is_bc;
  logic [CW-1:0]     pgn_cnt_new, pair_new, fmt_new, bsrc_new, src_new;
  logic [BYTE_W-1:0] pgn_src_new;
  logic [TW-1:0]     first_new, last_new;

  assign is_bc    = (id_q[23:16] >= BCAST_FORMAT);
  assign frame_we = cmd_i.execute && (cmd_q == CMD_FRAME);
  assign addr_we  = frame_we && !is_bc;
  assign bc_we    = frame_we && is_bc;

  assign pgn_cnt_new = is_bc ? sat_inc(pgn_cnt_rd) : pgn_cnt_rd;
  assign pgn_src_new = is_bc ? id_q[7:0] : pgn_src_rd;
  assign first_new   = ((pgn_first_rd == '0) || (t_q < pgn_first_rd)) ? t_q : pgn_first_rd;
  assign last_new    = ((pgn_last_rd == '0) || (t_q > pgn_last_rd)) ? t_q : pgn_last_rd;
  assign pair_new    = sat_inc(pair_rd);
  assign fmt_new     = sat_inc(fmt_rd);
  assign bsrc_new    = sat_inc(bsrc_rd);
  assign src_new     = sat_inc(src_rd);

  // per-pgn tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      pgn_cnt_mem[clr_q]   <= '0;
      pgn_pri_mem[clr_q]   <= '0;
      pgn_src_mem[clr_q]   <= '0;
      pgn_first_mem[clr_q] <= '0;
      pgn_last_mem[clr_q]  <= '0;
    end else if (frame_we) begin
      pgn_cnt_mem[pgn_a_q]   <= pgn_cnt_new;
      pgn_pri_mem[pgn_a_q]   <= id_q[28:26];
      pgn_src_mem[pgn_a_q]   <= pgn_src_new;
      pgn_first_mem[pgn_a_q] <= first_new;
      pgn_last_mem[pgn_a_q]  <= last_new;
    end
    pgn_cnt_rd   <= pgn_cnt_mem[pgn_ra];
    pgn_pri_rd   <= pgn_pri_mem[pgn_ra];
    pgn_src_rd   <= pgn_src_mem[pgn_ra];
    pgn_first_rd <= pgn_first_mem[pgn_ra];
    pgn_last_rd  <= pgn_last_mem[pgn_ra];
  end

  // source to destination pairs
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      pair_mem[clr_q] <= '0;
    end else if (addr_we) begin
      pair_mem[pair_a_q] <= pair_new;
    end
    pair_rd <= pair_mem[pair_ra];
  end

  // per-format counts
  always_ff @(posedge clk_i) begin
    if (small_clr) begin
      fmt_mem[clr_q[SMALL_AW-1:0]] <= '0;
    end else if (addr_we) begin
      fmt_mem[fmt_a_q] <= fmt_new;
    end
    fmt_rd <= fmt_mem[fmt_ra];
  end

  // broadcast source counts
  always_ff @(posedge clk_i) begin
    if (small_clr) begin
      bsrc_mem[clr_q[SMALL_AW-1:0]] <= '0;
    end else if (bc_we) begin
      bsrc_mem[src_a_q] <= bsrc_new;
    end
    bsrc_rd <= bsrc_mem[src_ra];
  end

  // all source counts
  always_ff @(posedge clk_i) begin
    if (small_clr) begin
      src_mem[clr_q[SMALL_AW-1:0]] <= '0;
    end else if (frame_we) begin
      src_mem[src_a_q] <= src_new;
    end
    src_rd <= src_mem[src_ra];
  end

  // line totals and log times
  logic [CW-1:0] line_q, line_d, good_q, good_d, bcast_q, bcast_d, addr_q, addr_d;
  logic [TW-1:0] log_start_q, log_start_d, log_end_q, log_end_d;

  always_comb begin
    line_d      = line_q;
    good_d      = good_q;
    bcast_d     = bcast_q;
    addr_d      = addr_q;
    log_start_d = log_start_q;
    log_end_d   = log_end_q;
    if (frame_we) begin
      line_d    = sat_inc(line_q);
      good_d    = sat_inc(good_q);
      log_end_d = t_q;
      if (good_q == '0) log_start_d = t_q;
      if (is_bc) bcast_d = sat_inc(bcast_q);
      else       addr_d  = sat_inc(addr_q);
    end else if (cmd_i.execute && (cmd_q == CMD_BAD)) begin
      line_d = sat_inc(line_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      good_q      <= '0;
      bcast_q     <= '0;
      addr_q      <= '0;
      log_start_q <= '0;
      log_end_q   <= '0;
    end else begin
      line_q      <= line_d;
      good_q      <= good_d;
      bcast_q     <= bcast_d;
      addr_q      <= addr_d;
      log_start_q <= log_start_d;
      log_end_q   <= log_end_d;
    end
  end

  // result fields
  logic [PRIO_W-1:0] r_prio;
  logic [BYTE_W-1:0] r_pf, r_ps, r_sa;
  logic              r_bc, idx_small;
  logic [CW-1:0]     r_cnt;
  logic [TW-1:0]     r_ft, r_lt;

  assign idx_small = (qi_q[INDEX_W-1:SMALL_AW] == '0);

  always_comb begin
    r_prio = '0;
    r_pf   = '0;
    r_ps   = '0;
    r_sa   = '0;
    r_bc   = 1'b0;
    r_cnt  = '0;
    r_ft   = '0;
    r_lt   = '0;
    if (cmd_q == CMD_FRAME) begin
      r_prio = id_q[28:26];
      r_pf   = id_q[23:16];
      r_ps   = id_q[15:8];
      r_sa   = id_q[7:0];
      r_bc   = is_bc;
      r_cnt  = pgn_cnt_new;
      r_ft   = first_new;
      r_lt   = last_new;
    end else if (cmd_q == CMD_QUERY) begin
      unique case (sel_q)
        SEL_PGN: begin
          r_prio = pgn_pri_rd;
          r_pf   = qi_q[15:8];
          r_ps   = qi_q[7:0];
          r_sa   = pgn_src_rd;
          r_bc   = (qi_q[15:8] >= BCAST_FORMAT);
          r_cnt  = pgn_cnt_rd;
          r_ft   = pgn_first_rd;
          r_lt   = pgn_last_rd;
        end
        SEL_FORMAT: if (idx_small) r_cnt = fmt_rd;
        SEL_BSRC:   if (idx_small) r_cnt = bsrc_rd;
        SEL_SRC:    if (idx_small) r_cnt = src_rd;
        SEL_PAIR:   r_cnt = pair_rd;
        default:    r_cnt = '0;
      endcase
    end
  end

  // output register
  logic                  out_valid_q;
  logic [PRIO_W-1:0]     o_prio_q;
  logic [BYTE_W-1:0]     o_pf_q, o_ps_q, o_sa_q;
  logic                  o_bc_q;
  logic [OUT_CNT_W-1:0]  o_cnt_q, o_line_q, o_good_q, o_bcast_q, o_addr_q;
  logic [OUT_TIME_W-1:0] o_ft_q, o_lt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      o_prio_q  <= r_prio;
      o_pf_q    <= r_pf;
      o_ps_q    <= r_ps;
      o_sa_q    <= r_sa;
      o_bc_q    <= r_bc;
      o_cnt_q   <= OUT_CNT_W'(r_cnt);
      o_ft_q    <= OUT_TIME_W'(r_ft);
      o_lt_q    <= OUT_TIME_W'(r_lt);
      o_line_q  <= OUT_CNT_W'(line_d);
      o_good_q  <= OUT_CNT_W'(good_d);
      o_bcast_q <= OUT_CNT_W'(bcast_d);
      o_addr_q  <= OUT_CNT_W'(addr_d);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.priority_res    = o_prio_q;
  assign out_o.pdu_format      = o_pf_q;
  assign out_o.pdu_specific    = o_ps_q;
  assign out_o.source_addr     = o_sa_q;
  assign out_o.is_broadcast    = o_bc_q;
  assign out_o.count_value     = o_cnt_q;
  assign out_o.first_time      = o_ft_q;
  assign out_o.last_time       = o_lt_q;
  assign out_o.total_lines     = o_line_q;
  assign out_o.read_frames     = o_good_q;
  assign out_o.broadcast_total = o_bcast_q;
  assign out_o.addressed_total = o_addr_q;

  assign in_i.ready = cmd_i.in_ready;

  // status
  assign sts_o.clr_last = &clr_q;
  assign sts_o.out_free = !out_valid_q || out_o.ready;
  assign sts_o.in_valid = in_i.valid;

endmodule

// File: rtl/j1939_traffic_statistics.sv
// J1939 traffic statistics.
// in_i carries one command per transfer: record a frame (29-bit identifier and
// microsecond stamp), count an unreadable line, or query one table entry
// selected by table_sel and query_index. out_o returns one result per command:
// decoded identifier fields, the pgn entry or queried count, and line totals.
// For each command the counter memories are first read at the incoming
// addresses as it is accepted; the execute state then updates and writes
// back the entries and loads the output register, and the result shows on
// out_o from there. A new command is not accepted until the current one has
// been executed, as the counter memories are read, modified and written back.
// After reset all tables are cleared by a sweep over the 65536 pgn and pair
// entries, one address a cycle, so in_i.ready stays low until the sweep ends.
// The result is held in the output register while out_o.ready is low; a new
// command is accepted in the cycle the pending result is taken.
// Counters saturate at all ones; a stored time of zero reads as unset.
module j1939_traffic_statistics import jts_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jts_in_if.sink    in_i,
  jts_out_if.source out_o
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  jts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (ctrl_sts),
    .cmd_o  (ctrl_cmd)
  );

  jts_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ctrl_cmd),
    .sts_o  (ctrl_sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
